>>> src/cfr_pkg.sv
// Shared types, constants and helpers for the CAN fragment frame reassembler.
package cfr_pkg;

  localparam int FRAGMENT_BYTES = 8;
  localparam int MAX_FRAGS = 3;
  localparam logic [3:0] FRAG_DLC = 4'(FRAGMENT_BYTES);
  localparam logic [15:0] TIMEOUT_RESET = 16'd50;

  localparam logic ACT_FRAGMENT = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED       = 3'd0,
    ST_BAD_LENGTH   = 3'd1,
    ST_ACCEPTED     = 3'd2,
    ST_REJECTED     = 3'd3,
    ST_POLL_IDLE    = 3'd4,
    ST_POLL_DROPPED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_HEADER    = 2'd1,
    REG_DOWN_TYPE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  header_byte;
    logic [7:0]  down_type_byte;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic [31:0] now_ms;
    logic [3:0]  data_length;
    logic [63:0] fragment;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        stale_dropped;
    logic [1:0]  fragments_held;
    logic [63:0] frame_first;
    logic [63:0] frame_middle;
    logic [63:0] frame_last;
  } result_t;

  // XOR of the eight bytes of one fragment word
  function automatic logic [7:0] byte_xor(input logic [63:0] w);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < FRAGMENT_BYTES; i++) begin
      acc = acc ^ w[8*i +: 8];
    end
    return acc;
  endfunction

endpackage

>>> src/cfr_in_if.sv
// Fragment/poll input channel.
interface cfr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] now_ms;
  logic [3:0]  data_length;
  logic [63:0] fragment;

  modport source (output valid, output action, output now_ms, output data_length,
                  output fragment, input ready);
  modport sink (input valid, input action, input now_ms, input data_length,
                input fragment, output ready);
endinterface

>>> src/cfr_out_if.sv
// Result channel.
interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        stale_dropped;
  logic [1:0]  fragments_held;
  logic [63:0] frame_first;
  logic [63:0] frame_middle;
  logic [63:0] frame_last;

  modport source (output valid, output status, output stale_dropped,
                  output fragments_held, output frame_first, output frame_middle,
                  output frame_last, input ready);
  modport sink (input valid, input status, input stale_dropped,
                input fragments_held, input frame_first, input frame_middle,
                input frame_last, output ready);
endinterface

>>> src/cfr_cfg_if.sv
// Configuration write channel.
interface cfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/cfr_regs.sv
// Configuration register file.
module cfr_regs
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms     <= TIMEOUT_RESET;
      cfg_r.header_byte    <= '0;
      cfg_r.down_type_byte <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TIMEOUT:   cfg_r.timeout_ms     <= wr_data;
        REG_HEADER:    cfg_r.header_byte    <= wr_data[7:0];
        REG_DOWN_TYPE: cfg_r.down_type_byte <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/cfr_assembler.sv
// Assembly state and single-step update: timeout, store, checksum and verdict.
module cfr_assembler
  import cfr_pkg::*;
#(
  parameter int FRAGMENT_COUNT = 3
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam logic [1:0] LAST_IDX = 2'(FRAGMENT_COUNT - 1);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] time_r, time_nxt;
  logic [63:0] buf_r [FRAGMENT_COUNT-1];

  logic [31:0] elapsed;
  logic        timed_out;
  logic        stale;
  logic [1:0]  cnt_base, cnt_eff;
  logic        completes;
  logic        store;
  logic [63:0] word [MAX_FRAGS];
  logic [7:0]  xor_all;
  logic        frame_ok;

  assign elapsed   = item.now_ms - time_r;
  assign timed_out = elapsed > {16'd0, cfg.timeout_ms};
  assign stale     = (cnt_r != 2'd0) && timed_out;
  assign cnt_base  = stale ? 2'd0 : cnt_r;
  assign cnt_eff   = (cnt_base > LAST_IDX) ? 2'd0 : cnt_base;
  assign completes = (cnt_eff == LAST_IDX);

  // frame words: buffered fragments first, the arriving one last
  for (genvar k = 0; k < MAX_FRAGS; k++) begin : g_word
    if (k < FRAGMENT_COUNT - 1) begin : g_buf
      assign word[k] = buf_r[k];
    end else if (k == FRAGMENT_COUNT - 1) begin : g_new
      assign word[k] = item.fragment;
    end else begin : g_none
      assign word[k] = '0;
    end
  end

  // XOR of bytes 0..N-2 equals byte N-1 <=> XOR of all bytes is zero
  assign xor_all  = byte_xor(word[0]) ^ byte_xor(word[1]) ^ byte_xor(word[2]);
  assign frame_ok = (word[0][63:56] == cfg.header_byte) &&
                    (word[0][55:48] == cfg.down_type_byte) &&
                    (xor_all == 8'd0);

  assign store = step && (item.action == ACT_FRAGMENT) &&
                 (item.data_length == FRAG_DLC) && !completes;

  always_comb begin
    res      = '0;
    cnt_nxt  = cnt_r;
    time_nxt = time_r;
    priority if (item.action == ACT_POLL) begin
      if ((cnt_r != 2'd0) && (time_r != 32'd0) && timed_out) begin
        cnt_nxt    = 2'd0;
        time_nxt   = 32'd0;
        res.status = ST_POLL_DROPPED;
      end else begin
        res.status = ST_POLL_IDLE;
      end
    end else if (item.data_length != FRAG_DLC) begin
      res.status = ST_BAD_LENGTH;
    end else begin
      res.stale_dropped = stale;
      if (completes) begin
        cnt_nxt  = 2'd0;
        time_nxt = 32'd0;
        if (frame_ok) begin
          res.status       = ST_ACCEPTED;
          res.frame_first  = word[0];
          res.frame_middle = word[1];
          res.frame_last   = word[2];
        end else begin
          res.status = ST_REJECTED;
        end
      end else begin
        cnt_nxt    = cnt_eff + 2'd1;
        time_nxt   = item.now_ms;
        res.status = ST_STORED;
      end
    end
    res.fragments_held = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      time_r <= '0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      time_r <= time_nxt;
    end
  end

  for (genvar k = 0; k < FRAGMENT_COUNT - 1; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (store && (cnt_eff == 2'(k))) begin
        buf_r[k] <= item.fragment;
      end
    end
  end

endmodule

>>> src/can_fragment_frame_reassembler_core.sv
// Top level of the CAN fragment frame reassembler.
// Takes one fragment or poll beat per clock while the output is not stalled, and
// returns one result beat for each. A beat accepted on in_ch lands in an input
// register; a step from that register then updates the assembly state (count,
// last time, buffered fragments) and loads the result register. The state update
// (timeout compare, store and XOR check of the completed frame) is combinational
// between the two registers. Both registers advance whenever the result register
// is empty or being drained, so a result drained in the same cycle never blocks
// the next input beat; while the output stalls, the block holds two beats and then
// drops in_ch.ready. Configuration writes (timeout_ms, header_byte,
// down_type_byte) are always taken; the user keeps them to idle periods, and the
// block itself does not enforce this.
module can_fragment_frame_reassembler_core
  import cfr_pkg::*;
#(
  parameter int FRAGMENT_COUNT = 3
) (
  input logic        clk,
  input logic        rst_n,
  cfr_in_if.sink     in_ch,
  cfr_out_if.source  out_ch,
  cfr_cfg_if.sink    cfg_ch
);

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  logic    step;
  cfg_t    cfg;
  result_t res;

  assign advance      = !out_valid_r || out_ch.ready;
  assign step         = in_valid_r && advance;
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  cfr_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  cfr_assembler #(
    .FRAGMENT_COUNT (FRAGMENT_COUNT)
  ) u_asm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid_r && in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end else if (!in_valid_r) begin
        in_valid_r <= in_ch.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.action      <= in_ch.action;
      in_item_r.now_ms      <= in_ch.now_ms;
      in_item_r.data_length <= in_ch.data_length;
      in_item_r.fragment    <= in_ch.fragment;
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.stale_dropped  = out_res_r.stale_dropped;
  assign out_ch.fragments_held = out_res_r.fragments_held;
  assign out_ch.frame_first    = out_res_r.frame_first;
  assign out_ch.frame_middle   = out_res_r.frame_middle;
  assign out_ch.frame_last     = out_res_r.frame_last;

endmodule

>>> src/cfr_checker.sv
// Port-level assertions for the reassembler core, with the bind that attaches them.
module cfr_checker
  import cfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_stale_dropped,
  input logic [1:0]  out_fragments_held,
  input logic [63:0] out_frame_first,
  input logic [63:0] out_frame_middle,
  input logic [63:0] out_frame_last
);

  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_restart_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPTED || out_status == ST_REJECTED ||
                  out_status == ST_POLL_DROPPED) |-> out_fragments_held == 2'd0)
    else $error("assembly not restarted after frame end or drop");

  a_stale_only_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD_LENGTH || out_status == ST_POLL_IDLE ||
                  out_status == ST_POLL_DROPPED) |-> !out_stale_dropped)
    else $error("stale drop flagged on a beat that stores nothing");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPTED |->
      out_frame_first == '0 && out_frame_middle == '0 && out_frame_last == '0)
    else $error("frame data on a result that is not an accepted frame");

endmodule

bind can_fragment_frame_reassembler_core cfr_checker u_cfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_stale_dropped  (out_ch.stale_dropped),
  .out_fragments_held (out_ch.fragments_held),
  .out_frame_first    (out_ch.frame_first),
  .out_frame_middle   (out_ch.frame_middle),
  .out_frame_last     (out_ch.frame_last)
);

>>> verif/cfr_frame_checker.sv
// Scoreboard for the fragment reassembler: predicts each result beat and checks the output.
module cfr_frame_checker
  import cfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cfr_in_if    in_ch,
  cfr_out_if   out_ch,
  cfr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   frames_accepted,
  output int   stale_drops
);

  localparam int FRAME_FRAGS = MAX_FRAGS;
  localparam int FRAME_LEN = FRAME_FRAGS * FRAGMENT_BYTES;
  localparam int PRINT_CAP = 40;

  cfg_t        regs;
  logic [63:0] held_frag [FRAME_FRAGS];
  logic [1:0]  frag_count;
  logic [31:0] last_time;
  result_t     expected_results [$];

  function automatic void clear_assembly();
    frag_count = '0;
    last_time = '0;
  endfunction

  function automatic logic frame_ok();
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] sum;
    sum = '0;
    for (int i = 0; i < FRAME_LEN; i++) begin
      fb[i] = held_frag[i / FRAGMENT_BYTES][63 - 8 * (i % FRAGMENT_BYTES) -: 8];
    end
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      sum = sum ^ fb[i];
    end
    return (fb[0] == regs.header_byte) && (fb[1] == regs.down_type_byte) &&
           (sum == fb[FRAME_LEN - 1]);
  endfunction

  function automatic result_t reassemble_step(input item_t beat);
    result_t     r;
    logic [31:0] age;
    r = '0;
    age = beat.now_ms - last_time;
    if (beat.action == ACT_POLL) begin
      // a fragment stored at time zero leaves last_time zero: polls never drop it
      if (frag_count != 0 && last_time != 0 && age > {16'd0, regs.timeout_ms}) begin
        clear_assembly();
        r.status = ST_POLL_DROPPED;
      end else begin
        r.status = ST_POLL_IDLE;
      end
    end else if (beat.data_length != FRAG_DLC) begin
      r.status = ST_BAD_LENGTH;
    end else begin
      if (frag_count != 0 && age > {16'd0, regs.timeout_ms}) begin
        clear_assembly();
        r.stale_dropped = 1'b1;
      end
      if (frag_count >= FRAME_FRAGS) clear_assembly();
      held_frag[frag_count] = beat.fragment;
      frag_count = frag_count + 2'd1;
      last_time = beat.now_ms;
      r.status = ST_STORED;
      if (frag_count >= FRAME_FRAGS) begin
        if (frame_ok()) begin
          r.status = ST_ACCEPTED;
          r.frame_first = held_frag[0];
          r.frame_middle = held_frag[1];
          r.frame_last = held_frag[2];
        end else begin
          r.status = ST_REJECTED;
        end
        clear_assembly();
      end
    end
    r.fragments_held = frag_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
    if (seen !== want) begin
      fail_count++;
      if (fail_count <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    item_t   beat;
    result_t want_r;
    if (!rst_n) begin
      regs.timeout_ms = TIMEOUT_RESET;
      regs.header_byte = '0;
      regs.down_type_byte = '0;
      clear_assembly();
      expected_results.delete();
      fail_count = 0;
      checked = 0;
      frames_accepted = 0;
      stale_drops = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_TIMEOUT:   regs.timeout_ms = cfg_ch.data;
          REG_HEADER:    regs.header_byte = cfg_ch.data[7:0];
          REG_DOWN_TYPE: regs.down_type_byte = cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        beat.action = in_ch.action;
        beat.now_ms = in_ch.now_ms;
        beat.data_length = in_ch.data_length;
        beat.fragment = in_ch.fragment;
        expected_results.push_back(reassemble_step(beat));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_CAP)
            $display("%0t: result beat with nothing expected, expected none actual status %0d",
                     $time, out_ch.status);
        end else begin
          want_r = expected_results.pop_front();
          check_field("status", 64'(want_r.status), 64'(out_ch.status));
          check_field("stale_dropped", 64'(want_r.stale_dropped), 64'(out_ch.stale_dropped));
          check_field("fragments_held", 64'(want_r.fragments_held), 64'(out_ch.fragments_held));
          check_field("frame_first", want_r.frame_first, out_ch.frame_first);
          check_field("frame_middle", want_r.frame_middle, out_ch.frame_middle);
          check_field("frame_last", want_r.frame_last, out_ch.frame_last);
          checked++;
          if (want_r.status == ST_ACCEPTED) frames_accepted++;
          if (want_r.stale_dropped) stale_drops++;
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> verif/can_fragment_frame_reassembler_core_test.sv
// Testbench top: drives fragments, polls and register writes, and reports the verdict.
module can_fragment_frame_reassembler_core_test;
  import cfr_pkg::*;

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 205;
  localparam int HOLD_CYCLES = 200;
  localparam int BURST_BEATS = 16;
  localparam int TAIL_CYCLES = 8;
  localparam int RUN_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst_n;

  cfr_in_if  in_bus ();
  cfr_out_if out_bus ();
  cfr_cfg_if cfg_bus ();

  int fail_count, pending, checked, frames_accepted, stale_drops;
  int send_idle_pct, recv_stall_pct, hold_req;
  int beats_sent, settings_done;
  cfg_t cur_cfg;
  logic [31:0] clock_ms;

  can_fragment_frame_reassembler_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  cfr_frame_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_bus),
    .out_ch          (out_bus),
    .cfg_ch          (cfg_bus),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .frames_accepted (frames_accepted),
    .stale_drops     (stale_drops)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: timeout with %0d results still expected", pending);
    $display("tb: failure");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever hold_req moves
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_beat(input logic act, input logic [31:0] now, input logic [3:0] dlc,
                           input logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.now_ms <= now;
    in_bus.data_length <= dlc;
    in_bus.fragment <= data;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_frag(input logic [31:0] now, input logic [63:0] data);
    send_beat(ACT_FRAGMENT, now, FRAG_DLC, data);
  endtask

  // polls carry junk in the unused fields
  task automatic send_poll(input logic [31:0] now);
    send_beat(ACT_POLL, now, 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_bad_length();
    logic [3:0] dlc;
    dlc = 4'($urandom);
    if (dlc == FRAG_DLC) dlc = 4'($urandom_range(7));
    send_beat(ACT_FRAGMENT, $urandom, dlc, {$urandom, $urandom});
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // byte registers get junk in the upper half of the data word
  task automatic write_settings(input logic [15:0] tmo, input logic [7:0] hdr,
                                input logic [7:0] dt);
    cfg_write(REG_TIMEOUT, tmo);
    cfg_write(REG_HEADER, {8'($urandom), hdr});
    cfg_write(REG_DOWN_TYPE, {8'($urandom), dt});
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
    cur_cfg.timeout_ms = tmo;
    cur_cfg.header_byte = hdr;
    cur_cfg.down_type_byte = dt;
    settings_done++;
  endtask

  // 24-byte frame, word 0 on top, last byte the XOR of the rest
  function automatic logic [191:0] good_frame(input logic [7:0] hdr, input logic [7:0] dt);
    logic [191:0] fr;
    logic [7:0]   sum;
    fr = {hdr, dt, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    sum = '0;
    for (int i = 0; i < 23; i++) sum = sum ^ fr[191 - 8 * i -: 8];
    fr[7:0] = sum;
    return fr;
  endfunction

  function automatic logic [31:0] advance_time();
    logic [31:0] tmo;
    int          r;
    tmo = {16'd0, cur_cfg.timeout_ms};
    r = $urandom_range(99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(tmo);
    else if (r < 78) clock_ms = clock_ms + tmo;
    else if (r < 85) clock_ms = clock_ms + tmo + 32'd1;
    else if (r < 92) clock_ms = clock_ms + $urandom;
    else if (r < 96) clock_ms = '0;
    else clock_ms = 32'hFFFF_FFFF - $urandom_range(tmo);
    return clock_ms;
  endfunction

  task automatic random_traffic(input int n);
    int           sent;
    int           r;
    int           flip;
    logic [191:0] fr;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        fr = good_frame(cur_cfg.header_byte, cur_cfg.down_type_byte);
        if ($urandom_range(9) == 0) begin
          flip = $urandom_range(191);
          fr[flip] = ~fr[flip];
        end
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(7) == 0) send_bad_length();
          if ($urandom_range(9) == 0) begin
            send_poll(advance_time());
            sent++;
          end
          send_frag(advance_time(), fr[191 - 64 * k -: 64]);
          sent++;
        end
      end else if (r < 75) begin
        send_frag(advance_time(), {$urandom, $urandom});
        sent++;
      end else if (r < 90) begin
        send_poll(advance_time());
        sent++;
      end else begin
        send_bad_length();
      end
    end
  endtask

  initial begin
    logic [191:0] fr;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_FRAGMENT;
    in_bus.now_ms = '0;
    in_bus.data_length = '0;
    in_bus.fragment = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_TIMEOUT;
    cfg_bus.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    beats_sent = 0;
    settings_done = 0;
    clock_ms = '0;
    cur_cfg.timeout_ms = TIMEOUT_RESET;
    cur_cfg.header_byte = '0;
    cur_cfg.down_type_byte = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, under the reset register values
    send_poll(32'd0);
    send_beat(ACT_FRAGMENT, 32'd3, 4'd0, '1);
    send_beat(ACT_FRAGMENT, 32'd7, 4'd15, '1);
    send_frag(32'd0, '0);
    send_poll(32'd1000);
    send_frag(32'd1000, '0);
    send_frag(32'd1050, '0);
    send_frag(32'd1100, '0);
    fr = good_frame(8'h00, 8'h00);
    send_frag(32'hFFFF_FFF0, fr[191:128]);
    send_frag(32'h0000_0010, fr[127:64]);
    send_frag(32'h0000_0020, fr[63:0]);
    send_frag(32'd5000, {$urandom, $urandom});
    send_poll(32'd5050);
    send_poll(32'd5051);
    send_poll(32'd5052);
    fr = good_frame(8'h00, 8'h00);
    fr[0] = ~fr[0];
    send_frag(32'd6000, fr[191:128]);
    send_frag(32'd6001, fr[127:64]);
    send_frag(32'd6002, fr[63:0]);
    fr = good_frame(8'h01, 8'h00);
    send_frag(32'd6010, fr[191:128]);
    send_frag(32'd6011, fr[127:64]);
    send_frag(32'd6012, fr[63:0]);
    fr = good_frame(8'h00, 8'h80);
    send_frag(32'd6020, fr[191:128]);
    send_frag(32'd6021, fr[127:64]);
    send_frag(32'd6022, fr[63:0]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 0) begin
        write_settings(16'h0000, 8'hFF, 8'hFF);
        // all-ones frame: odd count of 0xFF bytes XORs to 0xFF
        send_frag(32'd77, '1);
        send_frag(32'd77, '1);
        send_frag(32'd77, '1);
        send_frag(32'd200, '1);
        send_frag(32'd201, '1);
        clock_ms = 32'd201;
      end else if (ph == 1) begin
        write_settings(16'hFFFF, 8'h00, 8'h00);
        send_frag(32'd100, '0);
        send_frag(32'd100 + 32'd65535, '0);
        send_frag(32'd100 + 32'd65535 + 32'd65536, '0);
        clock_ms = 32'd100 + 32'd65535 + 32'd65536;
      end else begin
        write_settings(16'($urandom_range(300, 1)), 8'($urandom), 8'($urandom));
      end
      if (ph == 4) begin
        // output held off while the input keeps pushing
        hold_req++;
        @(negedge clk);
        for (int b = 0; b < BURST_BEATS; b++) send_frag(advance_time(), {$urandom, $urandom});
      end
      random_traffic(PHASE_ITEMS);
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("tb run: %0d beats under %0d register settings, four idle mixes, one long hold",
             beats_sent, settings_done);
    $display("tb run: %0d results checked, %0d frames accepted, %0d stale drops",
             checked, frames_accepted, stale_drops);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
